FILE: design/fupd_pkg.sv
// Shared types, constants and helper functions of the file URI percent decoder.
package fupd_pkg;

  // Length of the "file://" prefix.
  localparam logic [2:0] PREFIX_LEN = 3'd7;

  // The percent sign that opens an escape.
  localparam logic [7:0] CH_PCT = 8'h25;

  // Result status codes.
  localparam logic [1:0] ST_PATH     = 2'd0;
  localparam logic [1:0] ST_NOT_FILE = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  // Escape phase codes.
  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_PCT  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  // One input byte gives at most this many results.
  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [7:0] path_byte;
    logic [1:0] status;
    logic       end_of_path;
  } res_t;

  // All results caused by one input byte, first result in entry zero.
  typedef struct packed {
    logic [1:0]                cnt;
    res_t [MAX_RES-1:0]        res;
  } grp_t;

  // Expected character at each prefix position.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h66; // f
      3'd1:    c = 8'h69; // i
      3'd2:    c = 8'h6c; // l
      3'd3:    c = 8'h65; // e
      3'd4:    c = 8'h3a; // :
      3'd5:    c = 8'h2f; // /
      3'd6:    c = 8'h2f; // /
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic hex_valid(input logic [7:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h61) && (b <= 8'h66)) ||
           ((b >= 8'h41) && (b <= 8'h46));
  endfunction

  // Value of a character already known to be a hex digit.
  function automatic logic [3:0] hex_nibble(input logic [7:0] b);
    logic [3:0] v;
    if (b <= 8'h39) begin
      v = b[3:0];
    end else begin
      v = b[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic res_t make_res(input logic [7:0] b, input logic [1:0] st);
    res_t r;
    r.path_byte   = b;
    r.status      = st;
    r.end_of_path = 1'b0;
    return r;
  endfunction

endpackage

FILE: design/fupd_byte_if.sv
// Input channel: one URI byte per request with a last-byte flag.
interface fupd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] uri_byte;
  logic       is_last;

  modport source (output valid, output uri_byte, output is_last, input ready);
  modport sink   (input valid, input uri_byte, input is_last, output ready);
endinterface

FILE: design/fupd_res_if.sv
// Output channel: one decoded path byte or status per request.
interface fupd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;
  logic [1:0] status;
  logic       end_of_path;

  modport source (output valid, output path_byte, output status, output end_of_path,
                  input ready);
  modport sink   (input valid, input path_byte, input status, input end_of_path,
                  output ready);
endinterface

FILE: design/fupd_in_stage.sv
// Input register that holds one accepted URI byte until the decoder takes it.
module fupd_in_stage (
  input  logic        clk,
  input  logic        rst,
  fupd_byte_if.sink   uri,
  input  logic        advance,
  output logic        valid,
  output logic [7:0]  uri_byte,
  output logic        is_last
);

  assign uri.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (uri.ready) begin
      valid <= uri.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (uri.valid && uri.ready) begin
      uri_byte <= uri.uri_byte;
      is_last  <= uri.is_last;
    end
  end

endmodule

FILE: design/fupd_decode.sv
// Prefix check and escape decoding: per-URI state plus the result group of one byte.
module fupd_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        uri_byte,
  input  logic              is_last,
  output fupd_pkg::grp_t    grp
);
  import fupd_pkg::*;

  logic [2:0] prefix_count, prefix_count_next;
  logic       prefix_failed, prefix_failed_next;
  logic [1:0] escape_phase, escape_phase_next;
  logic [7:0] held_high_digit, held_high_digit_next;
  logic       emitted_any, emitted_any_next;

  logic [1:0]         cnt;
  res_t [MAX_RES-1:0] res;
  logic               is_pct;
  logic               is_hex;

  assign is_pct = (uri_byte == CH_PCT);
  assign is_hex = hex_valid(uri_byte);

  always_comb begin
    cnt                  = 2'd0;
    res                  = '0;
    prefix_count_next    = prefix_count;
    prefix_failed_next   = prefix_failed;
    escape_phase_next    = escape_phase;
    held_high_digit_next = held_high_digit;
    emitted_any_next     = emitted_any;

    if (!prefix_failed) begin
      if (prefix_count != PREFIX_LEN) begin
        if (uri_byte == prefix_char(prefix_count)) begin
          prefix_count_next = prefix_count + 3'd1;
        end else begin
          prefix_failed_next = 1'b1;
        end
      end else begin
        unique case (escape_phase)
          PH_PCT: begin
            if (is_hex) begin
              held_high_digit_next = uri_byte;
              escape_phase_next    = PH_HIGH;
            end else begin
              res[cnt] = make_res(CH_PCT, ST_PATH);
              cnt      = cnt + 2'd1;
              if (is_pct) begin
                escape_phase_next = PH_PCT;
              end else begin
                escape_phase_next = PH_NONE;
                res[cnt]          = make_res(uri_byte, ST_PATH);
                cnt               = cnt + 2'd1;
              end
            end
          end
          PH_HIGH: begin
            escape_phase_next = PH_NONE;
            if (is_hex) begin
              res[cnt] = make_res({hex_nibble(held_high_digit), hex_nibble(uri_byte)},
                                  ST_PATH);
              cnt      = cnt + 2'd1;
            end else begin
              res[cnt] = make_res(CH_PCT, ST_PATH);
              cnt      = cnt + 2'd1;
              res[cnt] = make_res(held_high_digit, ST_PATH);
              cnt      = cnt + 2'd1;
              if (is_pct) begin
                escape_phase_next = PH_PCT;
              end else begin
                res[cnt] = make_res(uri_byte, ST_PATH);
                cnt      = cnt + 2'd1;
              end
            end
          end
          default: begin
            if (is_pct) begin
              escape_phase_next = PH_PCT;
            end else begin
              escape_phase_next = PH_NONE;
              res[cnt]          = make_res(uri_byte, ST_PATH);
              cnt               = cnt + 2'd1;
            end
          end
        endcase
        // Every result so far in this branch is a path byte.
        emitted_any_next = emitted_any || (cnt != 2'd0);
      end
    end

    if (is_last) begin
      if (prefix_failed_next || (prefix_count_next != PREFIX_LEN)) begin
        // Not a file URI: whatever was produced is replaced by one status.
        res    = '0;
        res[0] = make_res(8'h00, ST_NOT_FILE);
        cnt    = 2'd1;
      end else begin
        // A pending escape cut off by the end goes out literally.
        if (escape_phase_next == PH_PCT) begin
          res[cnt] = make_res(CH_PCT, ST_PATH);
          cnt      = cnt + 2'd1;
        end else if (escape_phase_next == PH_HIGH) begin
          res[cnt] = make_res(CH_PCT, ST_PATH);
          cnt      = cnt + 2'd1;
          res[cnt] = make_res(held_high_digit_next, ST_PATH);
          cnt      = cnt + 2'd1;
        end
        if (!emitted_any_next && (cnt == 2'd0)) begin
          res[cnt] = make_res(8'h00, ST_EMPTY);
          cnt      = cnt + 2'd1;
        end
      end
      res[cnt - 2'd1].end_of_path = 1'b1;

      prefix_count_next    = 3'd0;
      prefix_failed_next   = 1'b0;
      escape_phase_next    = PH_NONE;
      held_high_digit_next = 8'h00;
      emitted_any_next     = 1'b0;
    end
  end

  assign grp.cnt = cnt;
  assign grp.res = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_count    <= 3'd0;
      prefix_failed   <= 1'b0;
      escape_phase    <= PH_NONE;
      held_high_digit <= 8'h00;
      emitted_any     <= 1'b0;
    end else if (fire) begin
      prefix_count    <= prefix_count_next;
      prefix_failed   <= prefix_failed_next;
      escape_phase    <= escape_phase_next;
      held_high_digit <= held_high_digit_next;
      emitted_any     <= emitted_any_next;
    end
  end

endmodule

FILE: design/fupd_out_queue.sv
// Result register that holds one result group and hands it out one request at a time.
module fupd_out_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  fupd_pkg::grp_t    grp,
  output logic              free,
  fupd_res_if.source        path
);
  import fupd_pkg::*;

  logic [1:0]         cnt;
  res_t [MAX_RES-1:0] res;
  logic               take;

  assign path.valid       = (cnt != 2'd0);
  assign path.path_byte   = res[0].path_byte;
  assign path.status      = res[0].status;
  assign path.end_of_path = res[0].end_of_path;

  assign take = path.valid && path.ready;
  assign free = (cnt == 2'd0) || (take && (cnt == 2'd1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= grp.cnt;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= grp.res;
    end else if (take) begin
      res <= {res_t'('0), res[MAX_RES-1:1]};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt == 2'd0) || (take && (cnt == 2'd1)))
    else $error("result group loaded over undelivered results");

  a_load_nonempty: assert property (@(posedge clk) disable iff (rst)
    load |=> path.valid)
    else $error("loaded result group shows no result");
`endif

endmodule

FILE: design/file_uri_percent_decoder.sv
// Top level of the file URI percent decoder: input register, decoder and result queue.
// A byte accepted from the input channel waits in the input register; when it leaves, its
// results are loaded into the result queue, which offers them on the output port.
// Throughput: one byte per cycle while each byte gives at most one result and the receiver
// is ready; a byte with two or three results holds the next byte back until all but its
// last are taken, as the output port moves one result per request. Reset is synchronous and
// active high: it clears prefix and escape state, empties input register and result queue.
module file_uri_percent_decoder (
  input  logic         clk,
  input  logic         rst,
  fupd_byte_if.sink    uri,
  fupd_res_if.source   path
);
  import fupd_pkg::*;

  // Input register contents.
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       stage_last;

  // Result group of the byte in the input register, computed combinationally.
  grp_t       grp;

  logic       q_free;
  logic       advance;
  logic       load;

  // A byte leaves the input register when its results fit into the result queue.
  // Bytes that give no result (prefix bytes, a percent sign that opens an escape, a high
  // digit) never wait on the output side.
  assign advance = stage_valid && ((grp.cnt == 2'd0) || q_free);
  assign load    = advance && (grp.cnt != 2'd0);

  fupd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .uri      (uri),
    .advance  (advance),
    .valid    (stage_valid),
    .uri_byte (stage_byte),
    .is_last  (stage_last)
  );

  // The decoder state moves forward exactly when the byte leaves the input register.
  fupd_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .fire     (advance),
    .uri_byte (stage_byte),
    .is_last  (stage_last),
    .grp      (grp)
  );

  fupd_out_queue u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .grp   (grp),
    .free  (q_free),
    .path  (path)
  );

`ifndef NO_ASSERTIONS
  a_status_ends_path: assert property (@(posedge clk) disable iff (rst)
    path.valid && (path.status != ST_PATH) |-> path.end_of_path)
    else $error("status result that does not end the path");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (rst)
    path.valid && (path.status != ST_PATH) |-> (path.path_byte == 8'h00))
    else $error("status result with a nonzero path byte");

  a_status_known: assert property (@(posedge clk) disable iff (rst)
    path.valid |-> (path.status <= ST_EMPTY))
    else $error("undefined status code on the output");
`endif

endmodule

FILE: tb/sv/fupd_path_checker.sv
// Checker that watches both channels, predicts the decoded path and compares each result.
`timescale 1ns / 1ps

module fupd_path_checker (
  input  logic clk,
  input  logic rst,
  fupd_byte_if uri,
  fupd_res_if  path,
  output int   mismatches,
  output int   outstanding
);
  import fupd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // The scheme that every accepted URI must open with.
  localparam logic [7:0] SCHEME [7] = '{"f", "i", "l", "e", ":", "/", "/"};

  // Predictor state, cleared by reset and at the end of every URI.
  logic [2:0] scheme_cnt;
  logic       scheme_bad;
  logic [1:0] esc_phase;
  logic [7:0] esc_high;
  logic       path_seen;

  // Results of the byte being predicted, and all results still to arrive.
  res_t step_q[$];
  res_t path_results_q[$];
  int   err_count;

  function automatic int hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic clear_uri_state();
    scheme_cnt = '0;
    scheme_bad = 1'b0;
    esc_phase  = PH_NONE;
    esc_high   = '0;
    path_seen  = 1'b0;
  endtask

  task automatic add_result(input logic [7:0] b, input logic [1:0] st);
    res_t r;
    r.path_byte   = b;
    r.status      = st;
    r.end_of_path = 1'b0;
    step_q.push_back(r);
    if (st == ST_PATH) path_seen = 1'b1;
  endtask

  // A byte with no escape open: either opens one or passes through.
  task automatic take_plain(input logic [7:0] b);
    if (b == CH_PCT) begin
      esc_phase = PH_PCT;
    end else begin
      add_result(b, ST_PATH);
    end
  endtask

  task automatic take_path_byte(input logic [7:0] b);
    int lo;
    int hi;
    lo = hex_val(b);
    case (esc_phase)
      PH_PCT: begin
        if (lo >= 0) begin
          esc_high  = b;
          esc_phase = PH_HIGH;
        end else begin
          esc_phase = PH_NONE;
          add_result(CH_PCT, ST_PATH);
          take_plain(b);
        end
      end
      PH_HIGH: begin
        hi        = hex_val(esc_high);
        esc_phase = PH_NONE;
        if (lo >= 0 && hi >= 0) begin
          add_result(8'((hi << 4) | lo), ST_PATH);
        end else begin
          add_result(CH_PCT, ST_PATH);
          add_result(esc_high, ST_PATH);
          take_plain(b);
        end
      end
      default: begin
        esc_phase = PH_NONE;
        take_plain(b);
      end
    endcase
  endtask

  task automatic decode_uri_byte(input logic [7:0] b, input logic last);
    step_q.delete();
    if (!scheme_bad) begin
      if (scheme_cnt < PREFIX_LEN) begin
        if (b == SCHEME[scheme_cnt]) scheme_cnt = scheme_cnt + 3'd1;
        else scheme_bad = 1'b1;
      end else begin
        take_path_byte(b);
      end
    end
    if (last) begin
      if (scheme_bad || scheme_cnt < PREFIX_LEN) begin
        step_q.delete();
        add_result(8'h00, ST_NOT_FILE);
      end else begin
        if (esc_phase == PH_PCT) begin
          add_result(CH_PCT, ST_PATH);
        end else if (esc_phase == PH_HIGH) begin
          add_result(CH_PCT, ST_PATH);
          add_result(esc_high, ST_PATH);
        end
        if (!path_seen) add_result(8'h00, ST_EMPTY);
      end
      step_q[step_q.size()-1].end_of_path = 1'b1;
      clear_uri_state();
    end
    foreach (step_q[i]) path_results_q.push_back(step_q[i]);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst) begin
      path_results_q.delete();
      clear_uri_state();
      err_count = 0;
    end else begin
      // Results first: a result never belongs to a byte taken at the same edge.
      if (path.valid && path.ready) begin
        got.path_byte   = path.path_byte;
        got.status      = path.status;
        got.end_of_path = path.end_of_path;
        if (path_results_q.size() == 0) begin
          if (err_count < REPORT_LIMIT)
            $display("Unexpected result: path_byte %02h status %0d end_of_path %0b",
                     got.path_byte, got.status, got.end_of_path);
          err_count++;
        end else begin
          want = path_results_q.pop_front();
          if (got.path_byte !== want.path_byte || got.status !== want.status ||
              got.end_of_path !== want.end_of_path) begin
            if (err_count < REPORT_LIMIT)
              $display("Mismatch: expected %02h/%0d/%0b, got %02h/%0d/%0b",
                       want.path_byte, want.status, want.end_of_path,
                       got.path_byte, got.status, got.end_of_path);
            err_count++;
          end
        end
      end
      if (uri.valid && uri.ready) decode_uri_byte(uri.uri_byte, uri.is_last);
    end
    mismatches  <= err_count;
    outstanding <= path_results_q.size();
  end

endmodule

FILE: tb/sv/file_uri_percent_decoder_tb.sv
// Top of the file URI percent decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module file_uri_percent_decoder_tb;
  import fupd_pkg::*;

  // Far above the slowest correct run: about 500 bytes, up to three results per
  // byte, each result waiting out a receiver that stalls most of the time.
  localparam int CYCLE_LIMIT  = 300000;
  // Cycles waited after the last expected result, to catch any stray result.
  localparam int DRAIN_CYCLES = 16;
  // Random bytes sent per idling phase; with the directed URIs this gives about
  // 500 bytes in all.
  localparam int PHASE_BYTES  = 120;

  logic clk;
  logic rst;
  int   cycles = 0;
  int   fail_cnt;
  int   pend_cnt;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   rand_bytes;

  // The URI about to be sent, one byte per entry.
  logic [7:0] uri_text[$];

  fupd_byte_if uri_ch ();
  fupd_res_if  path_ch ();

  file_uri_percent_decoder u_dut (
    .clk  (clk),
    .rst  (rst),
    .uri  (uri_ch),
    .path (path_ch)
  );

  fupd_path_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .uri         (uri_ch),
    .path        (path_ch),
    .mismatches  (fail_cnt),
    .outstanding (pend_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver decides at every falling edge whether it takes a result at the
  // next rising edge. Each step sees exactly one assignment to ready.
  initial begin
    path_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      path_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Offers one byte as a request and returns at the falling edge after the
  // block took it. Idle gaps drop valid only at edges where no new byte is
  // offered, so valid never falls and rises within one step.
  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      uri_ch.valid <= 1'b0;
      @(negedge clk);
    end
    uri_ch.valid    <= 1'b1;
    uri_ch.uri_byte <= b;
    uri_ch.is_last  <= last;
    @(posedge clk);
    while (!uri_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_uri();
    foreach (uri_text[i]) push_byte(uri_text[i], i == uri_text.size() - 1);
  endtask

  task automatic load_text(input string s);
    uri_text.delete();
    for (int i = 0; i < s.len(); i++) uri_text.push_back(s[i]);
  endtask

  task automatic send_text(input string s);
    load_text(s);
    send_uri();
  endtask

  // A random hex digit character, in either case for the letters.
  function automatic logic [7:0] rand_hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'("0" + d);
    if ($urandom_range(0, 1) == 1) return 8'("A" + d - 10);
    return 8'("a" + d - 10);
  endfunction

  // A byte that can never be a hex digit: '%' itself or anything from 'g' up.
  function automatic logic [7:0] rand_non_hex();
    if ($urandom_range(0, 3) == 0) return CH_PCT;
    return 8'($urandom_range(8'h67, 8'hff));
  endfunction

  // Most URIs carry the right scheme and a path mixing plain bytes, good
  // escapes and broken ones, so the decoder is exercised well past the prefix.
  // The rest are cut short, carry a damaged scheme, or are plain noise.
  task automatic build_random_uri();
    int kind;
    int len;
    int pos;
    kind = $urandom_range(0, 99);
    load_text("file://");
    if (kind < 85) begin
      len = $urandom_range(0, 10);
      repeat (len) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            uri_text.push_back(CH_PCT);
            uri_text.push_back(rand_hex_char());
            uri_text.push_back(rand_hex_char());
          end
          4: begin
            // A broken escape: a lone '%', or one digit and then a bad one.
            // When it ends the URI, the escape is cut by the end instead.
            uri_text.push_back(CH_PCT);
            if ($urandom_range(0, 1) == 1) uri_text.push_back(rand_hex_char());
            if ($urandom_range(0, 2) != 0) uri_text.push_back(rand_non_hex());
          end
          default: uri_text.push_back(8'($urandom_range(0, 255)));
        endcase
      end
    end else if (kind < 92) begin
      // Short URI: ends somewhere inside the scheme.
      len = $urandom_range(1, 6);
      while (uri_text.size() > len) void'(uri_text.pop_back());
    end else if (kind < 97) begin
      // One scheme byte is replaced, then some path follows.
      pos = $urandom_range(0, 6);
      uri_text[pos] = 8'($urandom_range(0, 255));
      if (uri_text[pos] == "f" && pos == 0) uri_text[pos] = "F";
      repeat ($urandom_range(0, 4)) uri_text.push_back(8'($urandom_range(0, 255)));
    end else begin
      uri_text.delete();
      repeat ($urandom_range(1, 8)) uri_text.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rand_bytes      = 0;
    src_idle_pct    = 25;
    sink_idle_pct   = 72;
    rst             = 1'b1;
    uri_ch.valid    = 1'b0;
    uri_ch.uri_byte = 8'h00;
    uri_ch.is_last  = 1'b0;

    // Synchronous reset, released at a falling edge.
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed URIs covering the special cases first.
    send_text("file://");               // empty path
    send_text("file:/");                // short URI
    send_text("fxle://a");              // scheme mismatch, the rest is ignored
    send_text("file:/x/a");             // mismatch at the last scheme byte
    send_text("file://%41%6a%FF%00");   // escapes in both cases, extremes of the byte
    send_text("file:///tmp%2Fx%2f");
    send_text("file://%");              // escape cut by the end after '%'
    send_text("file://%4");             // escape cut by the end after the high digit
    send_text("file://%4g");            // bad second digit
    send_text("file://%4%41");          // bad second digit that opens a new escape
    send_text("file://%%41");           // '%' right after '%'
    send_text("file://%zz");            // '%' with no hex digit at all
    // Raw zero and all-ones bytes are ordinary path bytes.
    load_text("file://");
    uri_text.push_back(8'h00);
    uri_text.push_back(8'hff);
    uri_text.push_back("a");
    send_uri();
    // One-byte URIs, good first letter and not.
    uri_text.delete();
    uri_text.push_back(8'hff);
    send_uri();
    send_text("f");

    // Random URIs under three idling patterns: sender light and receiver heavy,
    // then the reverse, then no idling on either side.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin src_idle_pct = 25; sink_idle_pct = 72; end
        1: begin src_idle_pct = 72; sink_idle_pct = 25; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      while (rand_bytes < (phase + 1) * PHASE_BYTES) begin
        build_random_uri();
        rand_bytes += uri_text.size();
        send_uri();
      end
    end
    uri_ch.valid <= 1'b0;

    // Wait for every expected result, then a few more cycles for strays.
    while (pend_cnt != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
